// ----- rtl/core/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table: table depth, request
// kinds, status codes, the stored entry layout and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int DEPTH = 16;
  localparam int IDXW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int KEYW  = 32;
  localparam int PAYW  = 64;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_LOOKUP = 3'd1;
  localparam logic [2:0] KIND_UPDATE = 3'd2;
  localparam logic [2:0] KIND_DELETE = 3'd3;
  localparam logic [2:0] KIND_DUMP   = 3'd4;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic signed [KEYW-1:0] key;
    logic [PAYW-1:0]        payload;
  } entry_t;

  localparam int ENTRYW = $bits(entry_t);

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_HEAD = 8'b0000_0010,
    ST_SCAN = 8'b0000_0100,
    ST_INS  = 8'b0000_1000,
    ST_FIND = 8'b0001_0000,
    ST_DEL  = 8'b0010_0000,
    ST_DUMP = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/skt_ram.sv -----
// ----------------------------------------------------------------------------
// skt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/skt_cmp.sv -----
// ----------------------------------------------------------------------------
// skt_cmp
// Shared signed key comparator used by the insert scan and the key search steps.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cmp (
  input  wire logic signed [skt_pkg::KEYW-1:0] req_key,
  input  wire logic signed [skt_pkg::KEYW-1:0] entry_key,
  output      skt_pkg::cmp_t                    result
);

  assign result = {(req_key == entry_key), (req_key < entry_key)};

endmodule

`default_nettype wire

// ----- rtl/core/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to DEPTH entries kept in ascending signed key order.
//
// The in_ channel takes one request (insert, lookup, update, delete, dump)
// at a time; in_stall stays high from acceptance until the request's last
// result has been loaded into the output register. The out_ channel gives
// one result per request, or one per entry for a dump of a non-empty table,
// with out_last on the final one. Kinds 5 to 7 are taken and dropped without
// a result. The steps of each request (an insert into an empty table only writes):
//   insert  head check, scan down from the tail moving entries up, then write
//   lookup, update  scan up from index 0 until the match or the last entry
//   delete  scan up to the match, then move each later entry down one slot
//   dump    read the entries in order, one result per cycle while out_stall is low
// One entry memory with registered read and one shared key comparator do
// the work: each step reads or moves one entry.
// Reset (rst_n low, synchronous) empties the table and the output register;
// the memory itself is not cleared. While out_stall is high the pending
// result holds and the sequencer waits at its next result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [2:0]                       in_kind,
  input  wire logic signed [skt_pkg::KEYW-1:0]  in_key,
  input  wire logic [skt_pkg::PAYW-1:0]         in_payload,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [1:0]                       out_status,
  output      logic signed [skt_pkg::KEYW-1:0]  out_key_out,
  output      logic [skt_pkg::PAYW-1:0]         out_payload_out,
  output      logic [4:0]                       out_entry_count,
  output      logic                             out_last
);

  skt_pkg::state_t                   state_r, state_nxt;
  logic [skt_pkg::IDXW-1:0]          idx_r, idx_nxt;
  logic [skt_pkg::CNTW-1:0]          count_r, count_nxt;
  logic                              front_r, front_nxt;
  logic [2:0]                        kind_r;
  logic signed [skt_pkg::KEYW-1:0]   key_r;
  logic [skt_pkg::PAYW-1:0]          payload_r;
  logic [1:0]                        res_status_r, res_status_nxt;
  logic signed [skt_pkg::KEYW-1:0]   res_key_r, res_key_nxt;
  logic [skt_pkg::PAYW-1:0]          res_payload_r, res_payload_nxt;

  logic                              out_valid_r;
  logic [1:0]                        out_status_r, out_status_d;
  logic signed [skt_pkg::KEYW-1:0]   out_key_r, out_key_d;
  logic [skt_pkg::PAYW-1:0]          out_payload_r, out_payload_d;
  logic [4:0]                        out_count_r;
  logic                              out_last_r, out_last_d;
  logic                              out_load;
  logic                              out_free;

  logic                              in_accept;
  logic                              ram_we;
  logic [skt_pkg::IDXW-1:0]          ram_waddr, ram_raddr;
  skt_pkg::entry_t                   wr_entry, rd_entry;
  logic [skt_pkg::ENTRYW-1:0]        rd_vec;
  skt_pkg::cmp_t                     cmp;
  logic                              idx_is_last;

  skt_ram #(
    .WIDTH (skt_pkg::ENTRYW),
    .DEPTH (skt_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_vec)
  );

  assign rd_entry = skt_pkg::entry_t'(rd_vec);

  skt_cmp u_cmp (
    .req_key   (key_r),
    .entry_key (rd_entry.key),
    .result    (cmp)
  );

  assign in_stall    = (state_r != skt_pkg::ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign idx_is_last = ((skt_pkg::CNTW'(idx_r) + skt_pkg::CNTW'(1)) == count_r);

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    res_status_nxt  = res_status_r;
    res_key_nxt     = res_key_r;
    res_payload_nxt = res_payload_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_r;
    ram_raddr       = '0;
    wr_entry        = rd_entry;
    out_load        = 1'b0;
    out_status_d    = skt_pkg::STAT_OK;
    out_key_d       = rd_entry.key;
    out_payload_d   = rd_entry.payload;
    out_last_d      = 1'b1;
    unique case (state_r)
      skt_pkg::ST_IDLE: begin
        if (in_accept) begin
          idx_nxt = '0;
          unique case (in_kind)
            skt_pkg::KIND_INSERT: begin
              if (count_r >= skt_pkg::CNTW'(skt_pkg::DEPTH)) begin
                res_status_nxt  = skt_pkg::STAT_FULL;
                res_key_nxt     = '0;
                res_payload_nxt = '0;
                state_nxt       = skt_pkg::ST_EMIT;
              end else if (count_r == '0) begin
                state_nxt = skt_pkg::ST_INS;
              end else begin
                state_nxt = skt_pkg::ST_HEAD;
              end
            end
            skt_pkg::KIND_LOOKUP, skt_pkg::KIND_UPDATE, skt_pkg::KIND_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt  = skt_pkg::STAT_NOTFOUND;
                res_key_nxt     = '0;
                res_payload_nxt = '0;
                state_nxt       = skt_pkg::ST_EMIT;
              end else begin
                state_nxt = skt_pkg::ST_FIND;
              end
            end
            skt_pkg::KIND_DUMP: begin
              if (count_r == '0) begin
                res_status_nxt  = skt_pkg::STAT_EMPTY;
                res_key_nxt     = '0;
                res_payload_nxt = '0;
                state_nxt       = skt_pkg::ST_EMIT;
              end else begin
                state_nxt = skt_pkg::ST_DUMP;
              end
            end
            default: begin
              state_nxt = skt_pkg::ST_IDLE;
            end
          endcase
        end
      end
      skt_pkg::ST_HEAD: begin
        // key at or below the first key goes to the front
        front_nxt = cmp.eq || cmp.lt;
        ram_raddr = skt_pkg::IDXW'(count_r - skt_pkg::CNTW'(1));
        idx_nxt   = skt_pkg::IDXW'(count_r - skt_pkg::CNTW'(1));
        state_nxt = skt_pkg::ST_SCAN;
      end
      skt_pkg::ST_SCAN: begin
        // walk down from the tail, moving larger entries up one slot
        if (front_r || cmp.lt) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r + skt_pkg::IDXW'(1);
          wr_entry  = rd_entry;
          if (idx_r == '0) begin
            state_nxt = skt_pkg::ST_INS;
          end else begin
            idx_nxt   = idx_r - skt_pkg::IDXW'(1);
            ram_raddr = idx_r - skt_pkg::IDXW'(1);
          end
        end else begin
          idx_nxt   = idx_r + skt_pkg::IDXW'(1);
          state_nxt = skt_pkg::ST_INS;
        end
      end
      skt_pkg::ST_INS: begin
        ram_we           = 1'b1;
        ram_waddr        = idx_r;
        wr_entry.key     = key_r;
        wr_entry.payload = payload_r;
        count_nxt        = count_r + skt_pkg::CNTW'(1);
        res_status_nxt   = skt_pkg::STAT_OK;
        res_key_nxt      = key_r;
        res_payload_nxt  = payload_r;
        state_nxt        = skt_pkg::ST_EMIT;
      end
      skt_pkg::ST_FIND: begin
        ram_raddr = idx_r + skt_pkg::IDXW'(1);
        if (cmp.eq) begin
          res_status_nxt  = skt_pkg::STAT_OK;
          res_key_nxt     = rd_entry.key;
          res_payload_nxt = rd_entry.payload;
          state_nxt       = skt_pkg::ST_EMIT;
          if (kind_r == skt_pkg::KIND_UPDATE) begin
            ram_we           = 1'b1;
            ram_waddr        = idx_r;
            wr_entry.key     = rd_entry.key;
            wr_entry.payload = payload_r;
            res_payload_nxt  = payload_r;
          end else if (kind_r == skt_pkg::KIND_DELETE) begin
            if (idx_is_last) begin
              count_nxt = count_r - skt_pkg::CNTW'(1);
            end else begin
              state_nxt = skt_pkg::ST_DEL;
            end
          end
        end else if (idx_is_last) begin
          res_status_nxt  = skt_pkg::STAT_NOTFOUND;
          res_key_nxt     = '0;
          res_payload_nxt = '0;
          state_nxt       = skt_pkg::ST_EMIT;
        end else begin
          idx_nxt = idx_r + skt_pkg::IDXW'(1);
        end
      end
      skt_pkg::ST_DEL: begin
        // close the gap, one entry down per cycle
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        wr_entry  = rd_entry;
        ram_raddr = idx_r + skt_pkg::IDXW'(2);
        idx_nxt   = idx_r + skt_pkg::IDXW'(1);
        if ((skt_pkg::CNTW'(idx_r) + skt_pkg::CNTW'(2)) >= count_r) begin
          count_nxt = count_r - skt_pkg::CNTW'(1);
          state_nxt = skt_pkg::ST_EMIT;
        end
      end
      skt_pkg::ST_DUMP: begin
        ram_raddr  = idx_r;
        out_last_d = idx_is_last;
        if (out_free) begin
          out_load = 1'b1;
          if (idx_is_last) begin
            state_nxt = skt_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + skt_pkg::IDXW'(1);
            ram_raddr = idx_r + skt_pkg::IDXW'(1);
          end
        end
      end
      skt_pkg::ST_EMIT: begin
        out_status_d  = res_status_r;
        out_key_d     = res_key_r;
        out_payload_d = res_payload_r;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = skt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = skt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    front_r       <= front_nxt;
    res_status_r  <= res_status_nxt;
    res_key_r     <= res_key_nxt;
    res_payload_r <= res_payload_nxt;
    if (in_accept) begin
      kind_r    <= in_kind;
      key_r     <= in_key;
      payload_r <= in_payload;
    end
    if (out_load) begin
      out_status_r  <= out_status_d;
      out_key_r     <= out_key_d;
      out_payload_r <= out_payload_d;
      out_count_r   <= 5'(count_r);
      out_last_r    <= out_last_d;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key_out     = out_key_r;
  assign out_payload_out = out_payload_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/core/skt_checker.sv -----
// ----------------------------------------------------------------------------
// skt_checker
// Port level checks of the sorted key table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic [2:0]                       in_kind,
  input wire logic signed [skt_pkg::KEYW-1:0]  in_key,
  input wire logic [skt_pkg::PAYW-1:0]         in_payload,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [1:0]                       out_status,
  input wire logic signed [skt_pkg::KEYW-1:0]  out_key_out,
  input wire logic [skt_pkg::PAYW-1:0]         out_payload_out,
  input wire logic [4:0]                       out_entry_count,
  input wire logic                             out_last
);

  // an accepted request of a known kind leaves the block busy in the next cycle
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == skt_pkg::KIND_INSERT ||
      in_kind == skt_pkg::KIND_LOOKUP || in_kind == skt_pkg::KIND_UPDATE ||
      in_kind == skt_pkg::KIND_DELETE || in_kind == skt_pkg::KIND_DUMP))
    |=> in_stall)
    else $error("block idle right after a request");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != skt_pkg::STAT_OK) |-> out_last)
    else $error("error result not marked last");

  a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != skt_pkg::STAT_OK)
    |-> (out_key_out == '0 && out_payload_out == '0))
    else $error("error result carries data");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == skt_pkg::STAT_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with entries");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == skt_pkg::STAT_FULL)
    |-> (out_entry_count == 5'(skt_pkg::DEPTH)))
    else $error("full status below depth");

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);

`default_nettype wire

// ----- tb/sv/sorted_key_table_test.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_test
// Self-checking testbench for the sorted key table. A shadow copy of the
// table predicts every result of each accepted request. A checker compares
// each accepted result with the oldest prediction. Directed tests cover the
// empty table, key ordering and duplicates, unknown kinds and the full table.
// Random phases follow, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_test;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * skt_pkg::DEPTH + 8;

  typedef struct packed {
    logic [1:0]                      status;
    logic signed [skt_pkg::KEYW-1:0] key;
    logic [skt_pkg::PAYW-1:0]        payload;
    logic [4:0]                      count;
    logic                            last;
  } table_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [2:0]                      in_kind = skt_pkg::KIND_INSERT;
  logic signed [skt_pkg::KEYW-1:0] in_key = '0;
  logic [skt_pkg::PAYW-1:0]        in_payload = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      out_status;
  logic signed [skt_pkg::KEYW-1:0] out_key_out;
  logic [skt_pkg::PAYW-1:0]        out_payload_out;
  logic [4:0]                      out_entry_count;
  logic                            out_last;

  logic signed [skt_pkg::KEYW-1:0] shadow_keys[skt_pkg::DEPTH];
  logic [skt_pkg::PAYW-1:0]        shadow_payloads[skt_pkg::DEPTH];
  int                              shadow_count = 0;
  table_result_t                   pending_results[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int request_count = 0;
  int results_checked = 0;
  int dump_count = 0;
  int quiet_cycles = 0;

  sorted_key_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_key_out     (out_key_out),
    .out_payload_out (out_payload_out),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic push_result(input logic [1:0] status,
                             input logic signed [skt_pkg::KEYW-1:0] key,
                             input logic [skt_pkg::PAYW-1:0] payload, input logic last);
    table_result_t r;
    r.status  = status;
    r.key     = key;
    r.payload = payload;
    r.count   = 5'(shadow_count);
    r.last    = last;
    pending_results.push_back(r);
  endtask

  task automatic apply_to_shadow_table(input logic [2:0] kind,
                                       input logic signed [skt_pkg::KEYW-1:0] key,
                                       input logic [skt_pkg::PAYW-1:0] payload);
    int pos;
    int hit;
    logic signed [skt_pkg::KEYW-1:0] hit_key;
    logic [skt_pkg::PAYW-1:0] hit_payload;
    case (kind)
      skt_pkg::KIND_INSERT: begin
        if (shadow_count >= skt_pkg::DEPTH) begin
          push_result(skt_pkg::STAT_FULL, '0, '0, 1'b1);
        end else begin
          pos = 0;
          if (shadow_count > 0 && key > shadow_keys[0]) begin
            while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i]     = shadow_keys[i-1];
            shadow_payloads[i] = shadow_payloads[i-1];
          end
          shadow_keys[pos]     = key;
          shadow_payloads[pos] = payload;
          shadow_count++;
          push_result(skt_pkg::STAT_OK, key, payload, 1'b1);
        end
      end
      skt_pkg::KIND_LOOKUP, skt_pkg::KIND_UPDATE, skt_pkg::KIND_DELETE: begin
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_keys[i] == key) hit = i;
        end
        if (hit < 0) begin
          push_result(skt_pkg::STAT_NOTFOUND, '0, '0, 1'b1);
        end else begin
          if (kind == skt_pkg::KIND_UPDATE) shadow_payloads[hit] = payload;
          hit_key     = shadow_keys[hit];
          hit_payload = shadow_payloads[hit];
          if (kind == skt_pkg::KIND_DELETE) begin
            for (int i = hit; i + 1 < shadow_count; i++) begin
              shadow_keys[i]     = shadow_keys[i+1];
              shadow_payloads[i] = shadow_payloads[i+1];
            end
            shadow_count--;
          end
          push_result(skt_pkg::STAT_OK, hit_key, hit_payload, 1'b1);
        end
      end
      skt_pkg::KIND_DUMP: begin
        dump_count++;
        if (shadow_count == 0) begin
          push_result(skt_pkg::STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            push_result(skt_pkg::STAT_OK, shadow_keys[i], shadow_payloads[i],
                        i + 1 == shadow_count);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // request stays on the port until taken; valid is left high for a following request
  task automatic send_request(input logic [2:0] kind,
                              input logic signed [skt_pkg::KEYW-1:0] key,
                              input logic [skt_pkg::PAYW-1:0] payload);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_key     <= key;
    in_payload <= payload;
    do @(posedge clk); while (in_stall);
    apply_to_shadow_table(kind, key, payload);
    request_count++;
  endtask

  task automatic wait_for_drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [skt_pkg::PAYW-1:0] random_payload;
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [skt_pkg::KEYW-1:0] pick_key;
    if (shadow_count > 0 && $urandom_range(0, 99) < 65)
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    if ($urandom_range(0, 1) == 0)
      return skt_pkg::KEYW'(int'($urandom_range(0, 15)) - 8);
    return $urandom;
  endfunction

  task automatic test_empty_table;
    send_request(skt_pkg::KIND_DUMP, '0, '0);
    send_request(skt_pkg::KIND_LOOKUP, 32'sd5, random_payload());
    send_request(skt_pkg::KIND_UPDATE, 32'h8000_0000, {skt_pkg::PAYW{1'b1}});
    send_request(skt_pkg::KIND_DELETE, 32'h7fff_ffff, '0);
    wait_for_drain();
  endtask

  task automatic test_key_order;
    send_request(skt_pkg::KIND_INSERT, 32'h7fff_ffff, {skt_pkg::PAYW{1'b1}});
    send_request(skt_pkg::KIND_INSERT, 32'h8000_0000, '0);
    send_request(skt_pkg::KIND_INSERT, 32'sd0, 64'h0123_4567_89ab_cdef);
    // equal keys keep insertion order
    send_request(skt_pkg::KIND_INSERT, 32'sd0, 64'hfedc_ba98_7654_3210);
    // a key equal to the front key goes to the front
    send_request(skt_pkg::KIND_INSERT, 32'h8000_0000, 64'h5555_5555_5555_5555);
    send_request(skt_pkg::KIND_INSERT, -32'sd1, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(skt_pkg::KIND_DUMP, '0, '0);
    send_request(skt_pkg::KIND_LOOKUP, 32'sd0, '0);
    send_request(skt_pkg::KIND_UPDATE, 32'sd0, {skt_pkg::PAYW{1'b1}});
    send_request(skt_pkg::KIND_DELETE, 32'sd0, '0);
    send_request(skt_pkg::KIND_DELETE, 32'h7fff_ffff, '0);
    send_request(skt_pkg::KIND_DELETE, 32'h8000_0000, '0);
    send_request(skt_pkg::KIND_LOOKUP, 32'h8000_0000, '0);
    send_request(skt_pkg::KIND_DUMP, '0, '0);
    wait_for_drain();
  endtask

  task automatic test_unknown_kinds;
    for (int k = 5; k <= 7; k++) send_request(3'(k), pick_key(), random_payload());
    send_request(skt_pkg::KIND_DUMP, '0, '0);
    wait_for_drain();
  endtask

  task automatic test_full_table;
    while (shadow_count < skt_pkg::DEPTH) begin
      send_request(skt_pkg::KIND_INSERT, pick_key(), random_payload());
    end
    send_request(skt_pkg::KIND_INSERT, 32'sd1, random_payload());
    send_request(skt_pkg::KIND_DUMP, '0, '0);
    send_request(skt_pkg::KIND_UPDATE, shadow_keys[skt_pkg::DEPTH-1], random_payload());
    send_request(skt_pkg::KIND_DELETE, shadow_keys[skt_pkg::DEPTH-1], '0);
    wait_for_drain();
  endtask

  task automatic random_request;
    int roll;
    int ins_pct;
    logic [2:0] kind;
    roll    = $urandom_range(0, 99);
    ins_pct = (shadow_count < skt_pkg::DEPTH / 2) ? 45 : 25;
    if (roll < 3) begin
      kind = 3'($urandom_range(5, 7));
    end else if (roll < 3 + ins_pct) begin
      kind = skt_pkg::KIND_INSERT;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2:    kind = skt_pkg::KIND_LOOKUP;
        3, 4:       kind = skt_pkg::KIND_UPDATE;
        5, 6, 7, 8: kind = skt_pkg::KIND_DELETE;
        default:    kind = skt_pkg::KIND_DUMP;
      endcase
    end
    send_request(kind, pick_key(), random_payload());
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) random_request();
    wait_for_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_key_order();
    test_unknown_kinds();
    test_full_table();
    test_random_phase(70, 0, 0);
    test_random_phase(70, 76, 0);
    test_random_phase(70, 0, 76);
    test_random_phase(70, 27, 27);
    $display("%0d requests sent, %0d dumps, %0d results checked", request_count,
             dump_count, results_checked);
    $display("covered empty, full, duplicate keys, unknown kinds, gaps and stalls");
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) begin : result_checker
    table_result_t expected_r;
    table_result_t actual_r;
    if (rst_n && out_valid && !out_stall) begin
      actual_r = '{out_status, out_key_out, out_payload_out, out_entry_count, out_last};
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d key %0d payload %h count %0d last %0d",
                 $time, actual_r.status, actual_r.key, actual_r.payload, actual_r.count,
                 actual_r.last);
        error_count++;
      end else begin
        expected_r = pending_results.pop_front();
        if (actual_r !== expected_r) begin
          $display("%0t: expected status %0d key %0d payload %h count %0d last %0d", $time,
                   expected_r.status, expected_r.key, expected_r.payload, expected_r.count,
                   expected_r.last);
          $display("%0t: actual   status %0d key %0d payload %h count %0d last %0d", $time,
                   actual_r.status, actual_r.key, actual_r.payload, actual_r.count,
                   actual_r.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

`default_nettype wire
